### rtl/core/pdfm_pkg.sv
// Shared field widths, register indexes and constants of the PWM duty and frequency meter.
package pdfm_pkg;

	// result field widths
	localparam int HIGH_W   = 24;
	localparam int LOW_W    = 24;
	localparam int PERIOD_W = 25;
	localparam int DUTY_W   = 17;
	localparam int FREQ_W   = 37;
	localparam int PNS_W    = 35;

	// configuration registers
	localparam int RATE_W     = 28;
	localparam int SP_W       = 20;
	localparam int CFG_DATA_W = 28;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd1;

	localparam logic [RATE_W-1:0] RATE_RST = 28'd1195005;
	localparam logic [SP_W-1:0]   SP_RST   = 20'd836817;

	// scale factors
	localparam int PS_PER_NS  = 1000;
	localparam int DUTY_SHIFT = 16;

endpackage

### rtl/core/pdfm_if.sv
// Request channels of the meter: pin samples in, measurement results out.
interface pdfm_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface pdfm_out_if;
	logic                          valid;
	logic                          ready;
	logic [pdfm_pkg::HIGH_W-1:0]   high_samples;
	logic [pdfm_pkg::LOW_W-1:0]    low_samples;
	logic [pdfm_pkg::PERIOD_W-1:0] period_samples;
	logic [pdfm_pkg::DUTY_W-1:0]   duty_q16;
	logic [pdfm_pkg::FREQ_W-1:0]   freq_millihertz;
	logic [pdfm_pkg::PNS_W-1:0]    period_ns;
	logic                          count_saturated;

	modport source (
		output valid, output high_samples, output low_samples, output period_samples,
		output duty_q16, output freq_millihertz, output period_ns, output count_saturated,
		input ready
	);
	modport sink (
		input valid, input high_samples, input low_samples, input period_samples,
		input duty_q16, input freq_millihertz, input period_ns, input count_saturated,
		output ready
	);
endinterface

### rtl/core/pwm_duty_frequency_meter.sv
// PWM duty-cycle and frequency meter: sample counter front end and serial arithmetic back end.
// One pin sample is taken per clock while ready is high. After reset or after a result the
// first sample arms the meter; if the pin is high it waits for a low, then for a rising edge,
// counts high samples up to the fall and low samples up to the next rise, and that closing
// rising sample ends the measurement. Counters stop at 2^COUNT_WIDTH-1 and raise
// count_saturated. The counts are then handed to a back end that works out duty (Q1.16),
// frequency (mHz) and period (ns), each rounded half up, through one bit-serial divider (one
// quotient bit per clock) of NUM_W = max(COUNT_WIDTH+22, 39) bits and a bit-serial multiplier
// (one bit of sample_period_ps per clock). The result waits on the three divider passes and
// the 20-step multiply, plus any wait of the output register on ready. Sampling continues
// while the back end works, except in the low phase of the next period: those samples, the
// closing one included, are held off (ready low) until the back end has passed its result to
// the output register.
module pwm_duty_frequency_meter #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdfm_pkg::CFG_DATA_W-1:0]     cfg_data,
	pdfm_in_if.sink                             in_ch,
	pdfm_out_if.source                          out_ch
);

	localparam int PER_W = COUNT_WIDTH + 1;
	localparam int DEN_W = (PER_W > 10) ? PER_W : 10;
	localparam int NUM_W = (PER_W + 21 > 39) ? PER_W + 21 : 39;
	localparam int EXT_W = (PER_W > 26) ? PER_W : 26;
	localparam int MUL_CNT_W = $clog2(pdfm_pkg::SP_W + 1);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// front end phases
	localparam logic [2:0] PH_ARM        = 3'd0;
	localparam logic [2:0] PH_WAIT_LOW   = 3'd1;
	localparam logic [2:0] PH_WAIT_HIGH  = 3'd2;
	localparam logic [2:0] PH_COUNT_HIGH = 3'd3;
	localparam logic [2:0] PH_COUNT_LOW  = 3'd4;

	// back end steps
	localparam logic [2:0] BK_IDLE = 3'd0;
	localparam logic [2:0] BK_DUTY = 3'd1;
	localparam logic [2:0] BK_FREQ = 3'd2;
	localparam logic [2:0] BK_MUL  = 3'd3;
	localparam logic [2:0] BK_PNS  = 3'd4;
	localparam logic [2:0] BK_OUT  = 3'd5;

	// configuration
	logic [pdfm_pkg::RATE_W-1:0] rate_q;
	logic [pdfm_pkg::SP_W-1:0]   sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= pdfm_pkg::RATE_RST;
			sp_q   <= pdfm_pkg::SP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pdfm_pkg::CFG_RATE:   rate_q <= cfg_data[pdfm_pkg::RATE_W-1:0];
				pdfm_pkg::CFG_PERIOD: sp_q   <= cfg_data[pdfm_pkg::SP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- front end: edge tracking and counting ----------------
	logic [2:0]             phase_q;
	logic [COUNT_WIDTH-1:0] hc_q;
	logic [COUNT_WIDTH-1:0] lc_q;
	logic                   sat_q;
	logic [2:0]             bk_q;

	logic                   hi;
	logic                   in_fire;
	logic                   handoff;
	logic [COUNT_WIDTH-1:0] hc_inc;
	logic [COUNT_WIDTH-1:0] lc_inc;

	always_comb begin
		hi      = in_ch.pin_level;
		in_fire = in_ch.valid & in_ch.ready;
		handoff = in_fire & (phase_q == PH_COUNT_LOW) & hi;
		hc_inc  = (hc_q == CNT_MAX) ? hc_q : hc_q + 1'b1;
		lc_inc  = (lc_q == CNT_MAX) ? lc_q : lc_q + 1'b1;
	end

	// low-phase samples, closing edge included, wait for a free back end
	assign in_ch.ready = !((phase_q == PH_COUNT_LOW) && (bk_q != BK_IDLE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ARM;
			hc_q    <= '0;
			lc_q    <= '0;
			sat_q   <= 1'b0;
		end else if (in_fire) begin
			case (phase_q)
				PH_ARM: begin
					hc_q    <= '0;
					lc_q    <= '0;
					sat_q   <= 1'b0;
					phase_q <= hi ? PH_WAIT_LOW : PH_WAIT_HIGH;
				end
				PH_WAIT_LOW: begin
					if (!hi)
						phase_q <= PH_WAIT_HIGH;
				end
				PH_WAIT_HIGH: begin
					if (hi) begin
						hc_q    <= COUNT_WIDTH'(1);
						phase_q <= PH_COUNT_HIGH;
					end
				end
				PH_COUNT_HIGH: begin
					if (hi) begin
						hc_q <= hc_inc;
						if (hc_inc == CNT_MAX)
							sat_q <= 1'b1;
					end else begin
						lc_q    <= COUNT_WIDTH'(1);
						phase_q <= PH_COUNT_LOW;
					end
				end
				PH_COUNT_LOW: begin
					if (!hi) begin
						lc_q <= lc_inc;
						if (lc_inc == CNT_MAX)
							sat_q <= 1'b1;
					end else begin
						phase_q <= PH_ARM;
					end
				end
				default: phase_q <= PH_ARM;
			endcase
		end
	end

	// ---------------- back end: serial arithmetic ----------------
	logic [COUNT_WIDTH-1:0] bh_q;
	logic [COUNT_WIDTH-1:0] bl_q;
	logic [PER_W-1:0]       per_q;
	logic                   bsat_q;
	logic                   div_start_q;
	logic [PER_W-1:0]       mul_hi_q;
	logic [pdfm_pkg::SP_W-1:0] mul_lo_q;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;
	logic [pdfm_pkg::DUTY_W-1:0] duty_q;
	logic [pdfm_pkg::FREQ_W-1:0] freq_q;
	logic [pdfm_pkg::PNS_W-1:0]  pns_q;

	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] div_quo;
	logic             div_done;
	logic [NUM_W-1:0] rate_ext;
	logic [NUM_W-1:0] half_per;
	logic [PER_W:0]   mul_sum;
	logic             per_zero;

	always_comb begin
		rate_ext = NUM_W'(rate_q);
		half_per = NUM_W'(per_q >> 1);
		per_zero = (per_q == '0);
		mul_sum  = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, per_q} : '0);
		case (bk_q)
			BK_DUTY: begin
				// high * 65536 / period
				div_num = (NUM_W'(bh_q) << pdfm_pkg::DUTY_SHIFT) + half_per;
				div_den = DEN_W'(per_q);
			end
			BK_FREQ: begin
				// rate * 1000 as 1024 - 16 - 8
				div_num = (rate_ext << 10) - (rate_ext << 4) - (rate_ext << 3) + half_per;
				div_den = DEN_W'(per_q);
			end
			BK_PNS: begin
				div_num = NUM_W'({mul_hi_q, mul_lo_q}) + NUM_W'(pdfm_pkg::PS_PER_NS / 2);
				div_den = DEN_W'(pdfm_pkg::PS_PER_NS);
			end
			default: begin
				div_num = '0;
				div_den = DEN_W'(per_q);
			end
		endcase
	end

	pdfm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// output register
	logic                            out_valid_q;
	logic [pdfm_pkg::HIGH_W-1:0]     o_high_q;
	logic [pdfm_pkg::LOW_W-1:0]      o_low_q;
	logic [pdfm_pkg::PERIOD_W-1:0]   o_per_q;
	logic [pdfm_pkg::DUTY_W-1:0]     o_duty_q;
	logic [pdfm_pkg::FREQ_W-1:0]     o_freq_q;
	logic [pdfm_pkg::PNS_W-1:0]      o_pns_q;
	logic                            o_sat_q;

	logic [EXT_W-1:0] h_ext;
	logic [EXT_W-1:0] l_ext;
	logic [EXT_W-1:0] p_ext;
	logic             out_free;
	logic             out_load;
	logic             div_go;

	always_comb begin
		h_ext    = EXT_W'(bh_q);
		l_ext    = EXT_W'(bl_q);
		p_ext    = EXT_W'(per_q);
		out_free = !out_valid_q || out_ch.ready;
		out_load = (bk_q == BK_OUT) && out_free;
		// divider kicks: on handoff, after duty, after the multiply
		div_go   = ((bk_q == BK_IDLE) && handoff) || ((bk_q == BK_DUTY) && div_done) ||
			((bk_q == BK_MUL) && (mul_cnt_q == MUL_CNT_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q        <= BK_IDLE;
			div_start_q <= 1'b0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= div_go;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			case (bk_q)
				BK_IDLE: begin
					if (handoff)
						bk_q <= BK_DUTY;
				end
				BK_DUTY: begin
					if (div_done)
						bk_q <= BK_FREQ;
				end
				BK_FREQ: begin
					if (div_done) begin
						bk_q      <= BK_MUL;
						mul_cnt_q <= MUL_CNT_W'(pdfm_pkg::SP_W);
					end
				end
				BK_MUL: begin
					mul_cnt_q <= mul_cnt_q - 1'b1;
					if (mul_cnt_q == MUL_CNT_W'(1))
						bk_q <= BK_PNS;
				end
				BK_PNS: begin
					if (div_done)
						bk_q <= BK_OUT;
				end
				BK_OUT: begin
					if (out_free)
						bk_q <= BK_IDLE;
				end
				default: bk_q <= BK_IDLE;
			endcase
		end
	end

	// back end payload
	always_ff @(posedge clk) begin
		if (handoff) begin
			bh_q   <= hc_q;
			bl_q   <= lc_q;
			per_q  <= PER_W'(hc_q) + PER_W'(lc_q);
			bsat_q <= sat_q;
		end
		if (bk_q == BK_DUTY && div_done)
			duty_q <= (per_zero || (|div_quo[NUM_W-1:pdfm_pkg::DUTY_W])) ?
				(per_zero ? '0 : '1) : div_quo[pdfm_pkg::DUTY_W-1:0];
		if (bk_q == BK_FREQ && div_done) begin
			freq_q <= (per_zero || (|div_quo[NUM_W-1:pdfm_pkg::FREQ_W])) ?
				(per_zero ? '0 : '1) : div_quo[pdfm_pkg::FREQ_W-1:0];
			mul_hi_q <= '0;
			mul_lo_q <= sp_q;
		end
		if (bk_q == BK_MUL) begin
			// shift-right product: add per into the upper half on each set bit
			mul_hi_q <= mul_sum[PER_W:1];
			mul_lo_q <= {mul_sum[0], mul_lo_q[pdfm_pkg::SP_W-1:1]};
		end
		if (bk_q == BK_PNS && div_done)
			pns_q <= (|div_quo[NUM_W-1:pdfm_pkg::PNS_W]) ? '1 :
				div_quo[pdfm_pkg::PNS_W-1:0];
		if (out_load) begin
			o_high_q <= (|h_ext[EXT_W-1:pdfm_pkg::HIGH_W]) ? '1 : h_ext[pdfm_pkg::HIGH_W-1:0];
			o_low_q  <= (|l_ext[EXT_W-1:pdfm_pkg::LOW_W]) ? '1 : l_ext[pdfm_pkg::LOW_W-1:0];
			o_per_q  <= (|p_ext[EXT_W-1:pdfm_pkg::PERIOD_W]) ? '1 :
				p_ext[pdfm_pkg::PERIOD_W-1:0];
			o_duty_q <= duty_q;
			o_freq_q <= freq_q;
			o_pns_q  <= pns_q;
			o_sat_q  <= bsat_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.high_samples    = o_high_q;
	assign out_ch.low_samples     = o_low_q;
	assign out_ch.period_samples  = o_per_q;
	assign out_ch.duty_q16        = o_duty_q;
	assign out_ch.freq_millihertz = o_freq_q;
	assign out_ch.period_ns       = o_pns_q;
	assign out_ch.count_saturated = o_sat_q;

endmodule

### rtl/core/pdfm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module pdfm_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule
